/* hw/rtl/scd_pkg.sv */
// Package with shared types, constants and calendar helpers for the date converter.
`default_nettype none

package scd_pkg;

  localparam logic [11:0] EPOCH_YEAR   = 12'd1950;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [16:0] SECS_PER_HR  = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN = 17'd60;
  localparam logic [16:0] DAYS_PER_WK  = 17'd7;

  // Reciprocals for the constant divisions, q = (n * RECIP) >> shift, exact over the
  // operand ranges. The power-of-two factor of each divisor is shifted out of n first.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // n = secs >> 7, by 675, shift 35
  localparam logic [25:0] HOUR_RECIP = 26'd9321;      // n = tod >> 4, by 225, shift 21
  localparam logic [25:0] MIN_RECIP  = 26'd1093;      // n = rem >> 2, by 15, shift 14
  localparam logic [25:0] WDAY_RECIP = 26'd74899;     // n = days, by 7, shift 19

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WDAY
  } div_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH
  } scd_state_e;

  typedef struct packed {
    logic    div_load;
    logic    div_step;
    div_op_e div_op;
    logic    year_init;
    logic    year_step;
    logic    month_step;
    logic    out_load;
  } scd_cmd_t;

  typedef struct packed {
    logic year_fit;
    logic month_fit;
  } scd_status_t;

  // Days before the start of month m (m = 0..12); the leap day counts from March on.
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/scd_datapath.sv */
// Datapath: shared reciprocal divider, year and month loops, and the output register.
`default_nettype none

module scd_datapath
  import scd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [31:0] secs_i,
  input  wire scd_cmd_t    cmd_i,
  output scd_status_t      status_o,
  output logic [11:0]      year_o,
  output logic [3:0]       month_o,
  output logic [4:0]       day_o,
  output logic [4:0]       hour_o,
  output logic [5:0]       minute_o,
  output logic [5:0]       second_o,
  output logic [2:0]       weekday_o
);

  // Divider: a load registers the reciprocal product, a step turns it into the
  // quotient and the remainder.
  logic [50:0] prod_q;
  logic [16:0] secs_lo_q;

  logic [15:0] days_q;
  logic [16:0] tod_q;
  logic [11:0] hrem_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [2:0]  weekday_q;
  logic [11:0] year_q;
  logic [15:0] dleft_q;
  logic [3:0]  month_q;

  logic [24:0] numer;
  logic [25:0] recip;
  logic [50:0] product;
  logic [16:0] divisor;
  logic [15:0] quo;
  logic [16:0] dvd;
  logic [16:0] qprod;
  logic [16:0] rem_calc;

  always_comb begin
    case (cmd_i.div_op)
      DIV_DAY: begin
        numer   = secs_i[31:7];
        recip   = DAY_RECIP;
        divisor = SECS_PER_DAY;
        quo     = prod_q[50:35];
        dvd     = secs_lo_q;
      end
      DIV_HOUR: begin
        numer   = {12'd0, tod_q[16:4]};
        recip   = HOUR_RECIP;
        divisor = SECS_PER_HR;
        quo     = {11'd0, prod_q[25:21]};
        dvd     = tod_q;
      end
      DIV_MIN: begin
        numer   = {15'd0, hrem_q[11:2]};
        recip   = MIN_RECIP;
        divisor = SECS_PER_MIN;
        quo     = {10'd0, prod_q[19:14]};
        dvd     = {5'd0, hrem_q};
      end
      default: begin
        numer   = {9'd0, days_q};
        recip   = WDAY_RECIP;
        divisor = DAYS_PER_WK;
        quo     = {3'd0, prod_q[31:19]};
        dvd     = {1'b0, days_q};
      end
    endcase
  end

  // The remainder is below 2^17, so only the low bits of the back product matter.
  assign product  = {26'd0, numer} * {25'd0, recip};
  assign qprod    = {1'b0, quo} * divisor;
  assign rem_calc = dvd - qprod;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      prod_q <= product;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load && (cmd_i.div_op == DIV_DAY)) begin
      secs_lo_q <= secs_i[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) begin
      case (cmd_i.div_op)
        DIV_DAY: begin
          days_q <= quo;
          tod_q  <= rem_calc;
        end
        DIV_HOUR: begin
          hour_q <= quo[4:0];
          hrem_q <= rem_calc[11:0];
        end
        DIV_MIN: begin
          minute_q <= quo[5:0];
          second_q <= rem_calc[5:0];
        end
        default: begin
          weekday_q <= rem_calc[2:0];
        end
      endcase
    end
  end

  // Within 1950..2086 the only century year is 2000, which is a leap year, so
  // divisibility by four decides.
  logic       leap;
  logic [8:0] ylen;
  logic [8:0] cum_hi;
  logic [8:0] cum_lo;
  logic [15:0] day_calc;

  assign leap   = (year_q[1:0] == 2'b00);
  assign ylen   = leap ? 9'd366 : 9'd365;
  assign cum_hi = cum_days(leap, month_q);
  assign cum_lo = cum_days(leap, month_q - 4'd1);

  assign status_o.year_fit  = (dleft_q < {7'd0, ylen});
  assign status_o.month_fit = (dleft_q < {7'd0, cum_hi});

  assign day_calc = dleft_q - {7'd0, cum_lo} + 16'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.year_init) begin
      year_q    <= EPOCH_YEAR;
      dleft_q   <= days_q;
      month_q   <= 4'd1;
    end else if (cmd_i.year_step) begin
      dleft_q <= dleft_q - {7'd0, ylen};
      year_q  <= year_q + 12'd1;
    end else if (cmd_i.month_step) begin
      month_q <= month_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      year_o    <= year_q;
      month_o   <= month_q;
      day_o     <= day_calc[4:0];
      hour_o    <= hour_q;
      minute_o  <= minute_q;
      second_o  <= second_q;
      weekday_o <= weekday_q;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/scd_ctrl.sv */
// Controller: sequences the divisions, the year and month loops, and the output handshake.
`default_nettype none

module scd_ctrl
  import scd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire scd_status_t status_i,
  output scd_cmd_t         cmd_o
);

  scd_state_e state_q, state_d;
  logic       phase_q, phase_d;
  logic       valid_q, valid_d;
  logic       accept;
  logic       can_load;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign can_load = !valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_DAY;
      ST_DAY:   state_d = ST_HOUR;
      ST_HOUR:  if (phase_q) state_d = ST_MIN;
      ST_MIN:   if (phase_q) state_d = ST_WDAY;
      ST_WDAY:  if (phase_q) state_d = ST_YEAR;
      ST_YEAR:  if (status_i.year_fit) state_d = ST_MONTH;
      ST_MONTH: if (status_i.month_fit && can_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // The division by 86400 is loaded at the accepting edge; the others first load and
  // then step, as the phase bit toggles.
  always_comb begin
    cmd_o        = '0;
    cmd_o.div_op = DIV_DAY;
    phase_d      = phase_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.div_load = accept;
      end
      ST_DAY: begin
        cmd_o.div_step = 1'b1;
      end
      ST_HOUR: begin
        cmd_o.div_op   = DIV_HOUR;
        cmd_o.div_load = !phase_q;
        cmd_o.div_step = phase_q;
        phase_d        = !phase_q;
      end
      ST_MIN: begin
        cmd_o.div_op   = DIV_MIN;
        cmd_o.div_load = !phase_q;
        cmd_o.div_step = phase_q;
        phase_d        = !phase_q;
      end
      ST_WDAY: begin
        cmd_o.div_op    = DIV_WDAY;
        cmd_o.div_load  = !phase_q;
        cmd_o.div_step  = phase_q;
        cmd_o.year_init = phase_q;
        phase_d         = !phase_q;
      end
      ST_YEAR: begin
        cmd_o.year_step = !status_i.year_fit;
      end
      ST_MONTH: begin
        cmd_o.month_step = !status_i.month_fit;
        cmd_o.out_load   = status_i.month_fit && can_load;
      end
      default: ;
    endcase
    valid_d = cmd_o.out_load ? 1'b1 : (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

/* hw/rtl/seconds_to_calendar_date_top.sv */
// Top level of the converter from epoch seconds to Gregorian date, time and weekday.
//
//   Channel   Direction  Handshake                       Payload
//   s_axis    in         s_axis_tvalid_i/s_axis_tready_o  seconds since 1950-01-01 00:00:00
//   m_axis    out        m_axis_tvalid_o/m_axis_tready_i  year, month, day, h, m, s, weekday
//
// One item is converted at a time. After the accepting edge come the divisions by 86400,
// 3600, 60 and 7, each a reciprocal multiply followed by a remainder step; the year
// loop then steps once per year past 1950, and the month search steps through the
// months, before the result is registered.
// The result sits in an output register; a new item is accepted while it waits,
// and the block stalls at the end of the month search only if the previous result
// has still not been taken. Reset clears the controller and the output valid flag.
`default_nettype none

module seconds_to_calendar_date_top
  import scd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] epoch_seconds
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [11:0] year, [15:12] month, [20:16] day, [25:21] hour, [31:26] minute,
  // [37:32] second, [40:38] weekday, [47:41] zero
  output logic [47:0]      m_axis_tdata_o
);

  scd_cmd_t    cmd;
  scd_status_t status;

  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  scd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  scd_datapath u_datapath (
    .clk_i     (clk_i),
    .secs_i    (s_axis_tdata_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .year_o    (year),
    .month_o   (month),
    .day_o     (day),
    .hour_o    (hour),
    .minute_o  (minute),
    .second_o  (second),
    .weekday_o (weekday)
  );

  // Fields packed from the lowest bit up, padded with zeros to six bytes.
  assign m_axis_tdata_o = {7'd0, weekday, second, minute, hour, day, month, year};

endmodule

`default_nettype wire
